>>> hw/rtl/debounced_threshold_alert_macros.svh
`ifndef DEBOUNCED_THRESHOLD_ALERT_MACROS_SVH
`define DEBOUNCED_THRESHOLD_ALERT_MACROS_SVH

// same-cycle implication, reset masked
`define DTA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define DTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/dta_pkg.sv
package dta_pkg;

	localparam int SampleWidth = 16;
	localparam int CountWidth  = 8;
	localparam int IndexWidth  = 2;

	typedef logic signed [SampleWidth-1:0] sample_t;
	typedef logic [CountWidth-1:0]         count_t;
	typedef logic [IndexWidth-1:0]         cfg_idx_t;
	typedef logic [SampleWidth-1:0]        cfg_data_t;

	typedef enum logic [2:0] {
		ST_NORMAL  = 3'd0,
		ST_PEND_HI = 3'd1,
		ST_ACT_HI  = 3'd2,
		ST_EXIT_HI = 3'd3,
		ST_PEND_LO = 3'd4,
		ST_ACT_LO  = 3'd5,
		ST_EXIT_LO = 3'd6
	} mode_t;

	localparam cfg_idx_t CFG_HIGH_THRESHOLD  = 2'd0;
	localparam cfg_idx_t CFG_LOW_THRESHOLD   = 2'd1;
	localparam cfg_idx_t CFG_DEBOUNCE_NEEDED = 2'd2;

	localparam sample_t HIGH_RESET = 16'sd2000;
	localparam sample_t LOW_RESET  = 16'sd1000;
	localparam count_t  NEED_RESET = 8'd3;
	localparam count_t  COUNT_MAX  = 8'd255;

	typedef struct packed {
		sample_t high_threshold;
		sample_t low_threshold;
		count_t  debounce_needed;
	} dta_cfg_t;

	typedef struct packed {
		mode_t  mode;
		count_t count;
		logic   raised;
	} dta_state_t;

endpackage

>>> hw/rtl/dta_if.sv
interface dta_sample_if;
	import dta_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface dta_result_if;
	import dta_pkg::*;

	logic       valid;
	logic       ready;
	logic [2:0] alert_state;
	logic       alert_on;
	count_t     run_count;

	modport source (output valid, output alert_state, output alert_on, output run_count,
		input ready);
	modport sink (input valid, input alert_state, input alert_on, input run_count,
		output ready);
endinterface

interface dta_cfg_if;
	import dta_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/debounced_threshold_alert.sv
// channel     | role | payload
// sample_ch   | sink | sample (16 bit signed)
// result_ch   | src  | alert_state (3), alert_on (1), run_count (8)
// cfg         | sink | index (2), data (16); always ready
//
// one item per cycle unless result stalls; items pass input, then state register
// the alert state register doubles as the result register, so it only moves
// when the result slot is free or being taken
// a stalled result holds the input register; input ready drops only when both are full
// reset clears thresholds to their defaults, the state to normal and all valids
module debounced_threshold_alert (
	input  logic          clk,
	input  logic          arst_n,
	dta_sample_if.sink    sample_ch,
	dta_result_if.source  result_ch,
	dta_cfg_if.sink       cfg
);
	import dta_pkg::*;

	logic       valid_s1;
	sample_t    sample_s1;
	logic       res_valid_q;
	logic       advance;
	dta_cfg_t   cfg_regs;
	dta_state_t state;

	assign advance         = valid_s1 && (!res_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign cfg.ready       = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample_ch.ready) begin
				valid_s1 <= sample_ch.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			sample_s1 <= sample_ch.sample;
		end
	end

	dta_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	dta_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.sample_s1 (sample_s1),
		.cfg       (cfg_regs),
		.state     (state)
	);

	assign result_ch.valid       = res_valid_q;
	assign result_ch.alert_state = state.mode;
	assign result_ch.alert_on    = state.raised;
	assign result_ch.run_count   = state.count;
endmodule

>>> hw/rtl/dta_cfg_regs.sv
module dta_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  dta_pkg::cfg_idx_t wr_index,
	input  dta_pkg::cfg_data_t wr_data,
	output dta_pkg::dta_cfg_t cfg
);
	import dta_pkg::*;

	dta_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_threshold  <= HIGH_RESET;
			cfg_q.low_threshold   <= LOW_RESET;
			cfg_q.debounce_needed <= NEED_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_HIGH_THRESHOLD:  cfg_q.high_threshold  <= sample_t'(wr_data);
				CFG_LOW_THRESHOLD:   cfg_q.low_threshold   <= sample_t'(wr_data);
				CFG_DEBOUNCE_NEEDED: cfg_q.debounce_needed <= wr_data[CountWidth-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> hw/rtl/dta_fsm.sv
module dta_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dta_pkg::sample_t    sample_s1,
	input  dta_pkg::dta_cfg_t   cfg,
	output dta_pkg::dta_state_t state
);
	import dta_pkg::*;

	dta_state_t state_q;
	dta_state_t state_d;
	logic       hi;
	logic       lo;
	count_t     bumped;
	logic       run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= ST_NORMAL;
			state_q.count  <= '0;
			state_q.raised <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		hi       = sample_s1 >= cfg.high_threshold;
		lo       = sample_s1 <= cfg.low_threshold;
		bumped   = (state_q.count == COUNT_MAX) ? state_q.count : state_q.count + count_t'(1);
		run_done = bumped >= cfg.debounce_needed;
		state_d  = state_q;
		case (state_q.mode)
			ST_PEND_HI: begin
				if (hi) begin
					state_d.count = bumped;
					if (run_done) begin
						state_d.mode   = ST_ACT_HI;
						state_d.raised = 1'b1;
					end
				end else if (lo) begin
					state_d.mode  = ST_PEND_LO;
					state_d.count = count_t'(1);
				end else begin
					state_d.mode  = ST_NORMAL;
					state_d.count = '0;
				end
			end
			ST_ACT_HI: begin
				if (!hi) begin
					state_d.mode  = ST_EXIT_HI;
					state_d.count = count_t'(1);
				end
			end
			ST_EXIT_HI: begin
				if (!hi) begin
					state_d.count = bumped;
					if (run_done) begin
						state_d.mode   = ST_NORMAL;
						state_d.raised = 1'b0;
					end
				end else begin
					state_d.mode  = ST_ACT_HI;
					state_d.count = '0;
				end
			end
			ST_PEND_LO: begin
				if (lo) begin
					state_d.count = bumped;
					if (run_done) begin
						state_d.mode   = ST_ACT_LO;
						state_d.raised = 1'b1;
					end
				end else if (hi) begin
					state_d.mode  = ST_PEND_HI;
					state_d.count = count_t'(1);
				end else begin
					state_d.mode  = ST_NORMAL;
					state_d.count = '0;
				end
			end
			ST_ACT_LO: begin
				if (!lo) begin
					state_d.mode  = ST_EXIT_LO;
					state_d.count = count_t'(1);
				end
			end
			ST_EXIT_LO: begin
				if (!lo) begin
					state_d.count = bumped;
					if (run_done) begin
						state_d.mode   = ST_NORMAL;
						state_d.raised = 1'b0;
					end
				end else begin
					state_d.mode  = ST_ACT_LO;
					state_d.count = '0;
				end
			end
			default: begin
				// normal, and the unused code
				if (hi) begin
					state_d.mode  = ST_PEND_HI;
					state_d.count = count_t'(1);
				end else if (lo) begin
					state_d.mode  = ST_PEND_LO;
					state_d.count = count_t'(1);
				end else begin
					state_d.mode = ST_NORMAL;
				end
			end
		endcase
	end

	assign state = state_q;
endmodule

>>> hw/rtl/dta_checker.sv
`include "debounced_threshold_alert_macros.svh"

module dta_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [2:0]       alert_state,
	input logic             alert_on,
	input dta_pkg::count_t  run_count
);
	import dta_pkg::*;

	logic raised_mode;
	logic pending_mode;

	assign raised_mode = (alert_state == ST_ACT_HI) || (alert_state == ST_EXIT_HI) ||
		(alert_state == ST_ACT_LO) || (alert_state == ST_EXIT_LO);
	assign pending_mode = (alert_state == ST_PEND_HI) || (alert_state == ST_EXIT_HI) ||
		(alert_state == ST_PEND_LO) || (alert_state == ST_EXIT_LO);

	`DTA_ASSERT_NOW(a_flag_matches_state, out_valid, alert_on == raised_mode, "alert flag disagrees with state")
	`DTA_ASSERT_NOW(a_no_unused_code, out_valid, alert_state != 3'd7, "unused state code on result")
	`DTA_ASSERT_NOW(a_pending_counts, out_valid && pending_mode, run_count != '0, "pending state with empty count")
	`DTA_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(alert_state) && $stable(alert_on) && $stable(run_count), "stalled result changed")
endmodule

bind debounced_threshold_alert dta_checker u_dta_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_ch.valid),
	.out_ready   (result_ch.ready),
	.alert_state (result_ch.alert_state),
	.alert_on    (result_ch.alert_on),
	.run_count   (result_ch.run_count)
);
